@@ rtl/rr_pkg.sv @@
// Shared widths, constants and arithmetic helpers for the tinted radiance resolver.
// No dependencies.
package rr_pkg;

    localparam int unsigned TintW   = 47;    // magnitude bits of a clamped tint sum / weight
    localparam int unsigned EffW    = 23;    // magnitude bits of effective positive light
    localparam int unsigned AccW    = 32;    // weight / 65535
    localparam int unsigned ColW    = 33;    // rounded colour, also clamped channel
    localparam int unsigned ColQW   = 32;    // colour divider quotient bits
    localparam int unsigned SclQW   = 17;    // scaling divider quotient bits
    localparam int unsigned NumW    = 70;    // tint * eff

    localparam logic [ColW-1:0]  SatRaw = 33'd40959;
    localparam logic [15:0]      Full16 = 16'hFFFF;
    localparam logic [TintW-1:0] Div16  = 47'd65535;

    typedef logic [15:0] t_rad;

    // floor(x / 65535) via x = a*65535 + (a + b), folded three times
    function automatic logic [AccW-1:0] div65535(input logic [TintW-1:0] x);
        logic [31:0] s1;
        logic [16:0] s2;
        logic [16:0] s3;
        logic        a2;
        s1 = {1'b0, x[46:16]} + {16'b0, x[15:0]};
        s2 = {1'b0, s1[31:16]} + {1'b0, s1[15:0]};
        a2 = s2[16];
        s3 = {16'b0, a2} + {1'b0, s2[15:0]};
        return {1'b0, x[46:16]} + {16'b0, s1[31:16]} + {31'b0, a2}
             + {31'b0, (s3 >= 17'd65535)};
    endfunction

    // 0 at 0, 65535 from 40959 up, else (8x+2)/5 by reciprocal (exact below 2^21/3)
    function automatic t_rad to_rad(input logic [ColW-1:0] x);
        logic [18:0] y;
        logic [37:0] p;
        y = {x[15:0], 3'b0} + 19'd2;
        p = {19'b0, y} * 38'd419431;
        if (x == '0) begin
            return '0;
        end else if (x >= SatRaw) begin
            return Full16;
        end else begin
            return p[36:21];
        end
    endfunction

endpackage

@@ rtl/rr_if.sv @@
// Valid/ready channel interfaces for the resolver's tile input and radiance output.
// No dependencies.
interface rr_in_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] tile_light;
    logic signed [23:0] positive_light;
    logic signed [47:0] red_tint_sum;
    logic signed [47:0] green_tint_sum;
    logic signed [47:0] blue_tint_sum;
    logic signed [47:0] tint_weight;
    modport source (output valid, tile_light, positive_light, red_tint_sum, green_tint_sum,
                    blue_tint_sum, tint_weight, input ready);
    modport sink (input valid, tile_light, positive_light, red_tint_sum, green_tint_sum,
                  blue_tint_sum, tint_weight, output ready);
endinterface

interface rr_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] mono_radiance;
    logic [15:0] red_radiance;
    logic [15:0] green_radiance;
    logic [15:0] blue_radiance;
    modport source (output valid, mono_radiance, red_radiance, green_radiance,
                    blue_radiance, input ready);
    modport sink (input valid, mono_radiance, red_radiance, green_radiance,
                  blue_radiance, output ready);
endinterface

@@ rtl/rr_delay.sv @@
// Enable-gated delay line for side data that rides along the pipeline.
// No dependencies.
module rr_delay #(
    parameter int unsigned W     = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);
    logic [W-1:0] r_sr [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sr[0] <= i_d;
            for (int i = 1; i < DEPTH; i++) begin
                r_sr[i] <= r_sr[i-1];
            end
        end
    end

    assign o_q = r_sr[DEPTH-1];
endmodule

@@ rtl/rr_divpipe.sv @@
// Restoring divider, one quotient bit per register stage.
// No dependencies. Initial remainder must be below the divisor.
module rr_divpipe #(
    parameter int unsigned DW = 47,
    parameter int unsigned QW = 32
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [DW-1:0] i_rem,
    input  logic [QW-1:0] i_low,
    input  logic [DW-1:0] i_div,
    output logic [QW-1:0] o_quo,
    output logic [DW-1:0] o_rem,
    output logic [DW-1:0] o_div
);
    logic [DW-1:0] r_rem [QW];
    logic [QW-1:0] r_low [QW];
    logic [QW-1:0] r_quo [QW];
    logic [DW-1:0] r_div [QW];

    for (genvar g = 0; g < QW; g++) begin : g_stage
        logic [DW-1:0] c_rem;
        logic [QW-1:0] c_low;
        logic [QW-1:0] c_quo;
        logic [DW-1:0] c_div;
        logic [DW:0]   s_try;
        logic [DW:0]   s_dif;
        logic          s_ge;

        if (g == 0) begin : g_head
            assign c_rem = i_rem;
            assign c_low = i_low;
            assign c_quo = '0;
            assign c_div = i_div;
        end else begin : g_body
            assign c_rem = r_rem[g-1];
            assign c_low = r_low[g-1];
            assign c_quo = r_quo[g-1];
            assign c_div = r_div[g-1];
        end

        assign s_try = {c_rem, c_low[QW-1]};
        assign s_ge  = s_try >= {1'b0, c_div};
        assign s_dif = s_try - {1'b0, c_div};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= s_ge ? s_dif[DW-1:0] : s_try[DW-1:0];
                r_low[g] <= {c_low[QW-2:0], 1'b0};
                r_quo[g] <= {c_quo[QW-2:0], s_ge};
                r_div[g] <= c_div;
            end
        end
    end

    assign o_quo = r_quo[QW-1];
    assign o_rem = r_rem[QW-1];
    assign o_div = r_div[QW-1];
endmodule

@@ rtl/rr_chan.sv @@
// One colour channel: split product, divider set-up, pipelined divide, half-up rounding.
// Depends on rr_pkg, rr_divpipe.
module rr_chan
    import rr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [TintW-1:0] i_tint,
    input  logic [EffW-1:0]  i_eff,
    input  logic             i_case_a,
    input  logic [TintW-1:0] i_w,
    output logic [ColW-1:0]  o_color
);
    logic [46:0]      r_lo;
    logic [45:0]      r_hi;
    logic [TintW-1:0] r3_t;
    logic [TintW-1:0] r3_w;
    logic             r3_case_a;
    logic             r3_nocol;
    logic [NumW-1:0]  n_num;
    logic [TintW-1:0] r4_rem;
    logic [ColQW-1:0] r4_low;
    logic [TintW-1:0] r4_div;
    logic [ColQW-1:0] d_quo;
    logic [TintW-1:0] d_rem;
    logic [TintW-1:0] d_div;
    logic [ColW-1:0]  r_color;

    // tint * eff as two narrow partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo      <= {23'b0, i_tint[23:0]} * {24'b0, i_eff};
            r_hi      <= {23'b0, i_tint[46:24]} * {23'b0, i_eff};
            r3_t      <= i_tint;
            r3_w      <= i_w;
            r3_case_a <= i_case_a;
            r3_nocol  <= (i_eff == '0);
        end
    end

    // below full weight: tint*eff / weight, else tint / 65535; no colour gives zero
    always_comb begin
        if (r3_case_a) begin
            n_num = {r_hi, 24'b0} + {23'b0, r_lo};
        end else if (r3_nocol) begin
            n_num = '0;
        end else begin
            n_num = {23'b0, r3_t};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_rem <= {9'b0, n_num[NumW-1:ColQW]};
            r4_low <= n_num[ColQW-1:0];
            r4_div <= r3_case_a ? r3_w : Div16;
        end
    end

    rr_divpipe #(.DW(TintW), .QW(ColQW)) u_div (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_rem (r4_rem),
        .i_low (r4_low),
        .i_div (r4_div),
        .o_quo (d_quo),
        .o_rem (d_rem),
        .o_div (d_div)
    );

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_color <= {1'b0, d_quo} + {32'b0, ({d_rem, 1'b0} >= {1'b0, d_div})};
        end
    end

    assign o_color = r_color;
endmodule

@@ rtl/tinted_radiance_resolver.sv @@
// Throughput: one transaction per cycle while o_out is not stalled; set by the 32-step
// colour divider and 17-step scaling divider, both fully pipelined.
// A stall on o_out freezes every stage together; nothing is lost or repeated.
// Reset (synchronous, active low) clears the stage valid bits only.
// Depends on rr_pkg, rr_if, rr_delay, rr_divpipe, rr_chan.
module tinted_radiance_resolver
    import rr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    rr_in_if.sink    i_in,
    rr_out_if.source o_out
);
    localparam int unsigned Lat   = 57;
    localparam int unsigned SCol  = 36;   // stage holding the rounded colour
    localparam int unsigned SCh   = 37;
    localparam int unsigned SScl  = 38;

    logic            en;
    logic [Lat-1:0]  r_vld;

    // stage 0: capture
    logic signed [23:0] r0_raw;
    logic signed [23:0] r0_pos;
    logic [TintW-1:0]   r0_t [3];
    logic signed [47:0] r0_w;
    logic [AccW-1:0]    r0_acc;

    // stage 1: effective light
    logic               w_pos;
    logic [EffW-1:0]    p_clamp;
    logic [EffW-1:0]    n_eff;
    logic [EffW-1:0]    r1_eff;
    logic               r1_case_a;
    logic signed [23:0] r1_raw;
    logic [TintW-1:0]   r1_w;
    logic [TintW-1:0]   r1_t [3];
    t_rad               r1_scal;

    logic [ColW-1:0]    color [3];
    logic [62:0]        side_a;
    logic signed [23:0] d_raw;
    logic [EffW-1:0]    d_eff;
    t_rad               d_scal;

    logic [ColW-1:0]    r_ch [3];
    t_rad               r37_scal;

    logic [ColW-1:0]    peak;
    logic               r38_scale;
    t_rad               r38_rad [3];
    t_rad               r38_scal;
    logic [ColW-1:0]    r38_rem [3];
    logic [SclQW-1:0]   r38_low [3];
    logic [ColW-1:0]    r38_div;

    logic [SclQW-1:0]   s_quo [3];
    logic [ColW-1:0]    s_rem [3];
    logic [ColW-1:0]    s_div [3];
    logic [64:0]        side_b;
    logic               d_scale;
    t_rad               d_rad [3];
    t_rad               d_scal2;

    t_rad               r_out [4];

    assign en         = !r_vld[Lat-1] || o_out.ready;
    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[Lat-2:0], i_in.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_raw  <= i_in.tile_light;
            r0_pos  <= i_in.positive_light;
            r0_t[0] <= i_in.red_tint_sum[47]   ? '0 : i_in.red_tint_sum[46:0];
            r0_t[1] <= i_in.green_tint_sum[47] ? '0 : i_in.green_tint_sum[46:0];
            r0_t[2] <= i_in.blue_tint_sum[47]  ? '0 : i_in.blue_tint_sum[46:0];
            r0_w    <= i_in.tint_weight;
            r0_acc  <= div65535(i_in.tint_weight[46:0]);
        end
    end

    assign w_pos   = !r0_w[47] && (r0_w != '0);
    assign p_clamp = r0_pos[23] ? '0 : r0_pos[22:0];
    assign n_eff   = !w_pos ? '0 : (({9'b0, p_clamp} > r0_acc) ? r0_acc[EffW-1:0] : p_clamp);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_eff    <= n_eff;
            r1_case_a <= (n_eff != '0) && ({9'b0, n_eff} < r0_acc);
            r1_raw    <= r0_raw;
            r1_w      <= r0_w[46:0];
            r1_t      <= r0_t;
            r1_scal   <= to_rad(r0_raw[23] ? '0 : {10'b0, r0_raw[22:0]});
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_ch
        rr_chan u_chan (
            .i_clk    (i_clk),
            .i_en     (en),
            .i_tint   (r1_t[k]),
            .i_eff    (r1_eff),
            .i_case_a (r1_case_a),
            .i_w      (r1_w),
            .o_color  (color[k])
        );
    end

    rr_delay #(.W(63), .DEPTH(SCol - 1)) u_side_a (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   ({r1_raw, r1_eff, r1_scal}),
        .o_q   (side_a)
    );
    assign d_raw  = side_a[62:39];
    assign d_eff  = side_a[38:16];
    assign d_scal = side_a[15:0];

    // raw - eff + colour, floored at zero
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                logic signed [34:0] v;
                v = $signed({{11{d_raw[23]}}, d_raw}) - $signed({12'b0, d_eff})
                  + $signed({2'b0, color[k]});
                r_ch[k] <= v[34] ? '0 : v[ColW-1:0];
            end
            r37_scal <= d_scal;
        end
    end

    always_comb begin
        peak = r_ch[0];
        if (r_ch[1] > peak) begin
            peak = r_ch[1];
        end
        if (r_ch[2] > peak) begin
            peak = r_ch[2];
        end
    end

    // ch * 65536 / peak: initial remainder is ch >> 1
    always_ff @(posedge i_clk) begin
        if (en) begin
            r38_scale <= peak > SatRaw;
            r38_div   <= peak;
            r38_scal  <= r37_scal;
            for (int k = 0; k < 3; k++) begin
                r38_rad[k] <= to_rad(r_ch[k]);
                r38_rem[k] <= {1'b0, r_ch[k][ColW-1:1]};
                r38_low[k] <= {r_ch[k][0], 16'b0};
            end
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_scl
        rr_divpipe #(.DW(ColW), .QW(SclQW)) u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_rem (r38_rem[k]),
            .i_low (r38_low[k]),
            .i_div (r38_div),
            .o_quo (s_quo[k]),
            .o_rem (s_rem[k]),
            .o_div (s_div[k])
        );
    end

    rr_delay #(.W(65), .DEPTH(SclQW)) u_side_b (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   ({r38_scale, r38_rad[0], r38_rad[1], r38_rad[2], r38_scal}),
        .o_q   (side_b)
    );
    assign d_scale  = side_b[64];
    assign d_rad[0] = side_b[63:48];
    assign d_rad[1] = side_b[47:32];
    assign d_rad[2] = side_b[31:16];
    assign d_scal2  = side_b[15:0];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                logic [17:0] q;
                q = {1'b0, s_quo[k]} + {17'b0, ({s_rem[k], 1'b0} >= {1'b0, s_div[k]})};
                if (!d_scale) begin
                    r_out[k+1] <= d_rad[k];
                end else if (q > {2'b0, Full16}) begin
                    r_out[k+1] <= Full16;
                end else begin
                    r_out[k+1] <= q[15:0];
                end
            end
            r_out[0] <= d_scal2;
        end
    end

    assign o_out.valid          = r_vld[Lat-1];
    assign o_out.mono_radiance  = r_out[0];
    assign o_out.red_radiance   = r_out[1];
    assign o_out.green_radiance = r_out[2];
    assign o_out.blue_radiance  = r_out[3];

    a_scale_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[SScl] && r38_scale |->
            (r38_rem[0] < r38_div) && (r38_rem[1] < r38_div) && (r38_rem[2] < r38_div))
        else $error("scaling divider remainder not below peak");

    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> $stable(r_vld))
        else $error("pipeline moved during output stall");

    a_reset_clears: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out.valid)
        else $error("output valid after reset");

    a_chan_stage_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[SCh] && en |=> r_vld[SScl])
        else $error("valid bit lost between channel and scaling stages");

endmodule
